[hw/rtl/etsf_pkg.sv]
// Shared types, constants and tables for the event-triggered state feedback unit.
package etsf_pkg;

    localparam int NUM_STATE_IN = 4;

    localparam int DATA_W  = 32;                 // signed Q16.16 fields
    localparam int UQ_W    = 31;                 // unsigned Q15.16 fields
    localparam int MUL_W   = 33;                 // signed operand of the shared multiplier
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 66;                 // exact sum of up to five Q32.32 products
    localparam int SHIFT_W = ACC_W - 16;
    localparam int Y_W     = 27;                 // exp argument in Q0.31, below 1/16
    localparam int E_W     = 17;                 // exp result in Q16.16, 0..1.0
    localparam int K_W     = 4;

    localparam int IN_TDATA_W  = 192;
    localparam int OUT_TDATA_W = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_1      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_2      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_3      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_REF    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LEVEL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_SCALE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE  = 3'd7;

    localparam logic [K_W-1:0] SERIES_TERMS = 4'd10;
    localparam logic [K_W-1:0] SQ_LAST      = 4'd7;   // eight squarings, 0..7
    localparam logic [K_W-1:0] K_FIRST_TERM = 4'd1;

    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
    localparam logic [63:0] SQ_HALF = 64'h0000_0000_4000_0000;
    localparam logic [31:0] E_HALF  = 32'h0000_4000;
    localparam logic [E_W-1:0] E_ONE = 17'h1_0000;

    localparam logic signed [SHIFT_W-1:0] SAT_HI = SHIFT_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [SHIFT_W-1:0] SAT_LO = SHIFT_W'(-64'sh0000_0000_8000_0000);
    localparam logic signed [DATA_W-1:0]  CAND_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0]  CAND_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DOT_M,
        S_DOT_W,
        S_SAT,
        S_X_M,
        S_X_W,
        S_SER_M,
        S_SER_W,
        S_DIV_M,
        S_DIV_W,
        S_SQ_M,
        S_SQ_W,
        S_ERND,
        S_SC_M,
        S_SC_W,
        S_DEC
    } t_state;

    typedef enum logic [2:0] {
        MOP_DOT,
        MOP_X,
        MOP_SER,
        MOP_DIV,
        MOP_SQ,
        MOP_SCL
    } t_mop;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_DOT,
        WB_SAT,
        WB_X,
        WB_SER,
        WB_DIV,
        WB_SQ,
        WB_ERND,
        WB_SCL,
        WB_DEC
    } t_wb;

    typedef struct packed {
        logic           ready;
        logic           mul_en;
        t_mop           mop;
        t_wb            wb;
        logic [K_W-1:0] k;
    } t_ctrl;

    typedef struct packed {
        logic time_zero;
        logic exp_cut;
        logic out_free;
    } t_stat;

    // ceil(2^32 / k); exact floor division for numerators below 2^27
    function automatic logic [31:0] f_recip(input logic [K_W-1:0] k);
        logic [31:0] r;
        case (k)
            4'd2:    r = 32'd2147483648;
            4'd3:    r = 32'd1431655766;
            4'd4:    r = 32'd1073741824;
            4'd5:    r = 32'd858993460;
            4'd6:    r = 32'd715827883;
            4'd7:    r = 32'd613566757;
            4'd8:    r = 32'd536870912;
            4'd9:    r = 32'd477218589;
            4'd10:   r = 32'd429496730;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/etsf_mul.sv]
// Shared signed multiplier with registered product.
module etsf_mul
    import etsf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

[hw/rtl/etsf_seq.sv]
// Sequencer: steps the shared multiplier through dot product, exp and threshold.
module etsf_seq
    import etsf_pkg::*;
#(
    parameter int N_ACT = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_state         r_state, n_state;
    logic [K_W-1:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DOT_M;
                    n_k     = '0;
                end
            end
            S_DOT_M: n_state = S_DOT_W;
            S_DOT_W: begin
                if (r_k == K_W'(N_ACT)) begin
                    n_state = S_SAT;
                end else begin
                    n_state = S_DOT_M;
                    n_k     = r_k + 1'b1;
                end
            end
            S_SAT: n_state = i_stat.time_zero ? S_DEC : S_X_M;
            S_X_M: n_state = S_X_W;
            S_X_W: begin
                if (i_stat.exp_cut) begin
                    n_state = S_SC_M;
                end else begin
                    n_state = S_SER_M;
                    n_k     = K_FIRST_TERM;
                end
            end
            S_SER_M: n_state = S_SER_W;
            S_SER_W: begin
                // first term needs no division
                if (r_k == K_FIRST_TERM) begin
                    n_state = S_SER_M;
                    n_k     = r_k + 1'b1;
                end else begin
                    n_state = S_DIV_M;
                end
            end
            S_DIV_M: n_state = S_DIV_W;
            S_DIV_W: begin
                if (r_k == SERIES_TERMS) begin
                    n_state = S_SQ_M;
                    n_k     = '0;
                end else begin
                    n_state = S_SER_M;
                    n_k     = r_k + 1'b1;
                end
            end
            S_SQ_M: n_state = S_SQ_W;
            S_SQ_W: begin
                if (r_k == SQ_LAST) begin
                    n_state = S_ERND;
                end else begin
                    n_state = S_SQ_M;
                    n_k     = r_k + 1'b1;
                end
            end
            S_ERND: n_state = S_SC_M;
            S_SC_M: n_state = S_SC_W;
            S_SC_W: n_state = S_DEC;
            S_DEC: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctrl.ready  = 1'b0;
        o_ctrl.mul_en = 1'b0;
        o_ctrl.mop    = MOP_DOT;
        o_ctrl.wb     = WB_NONE;
        o_ctrl.k      = r_k;
        unique case (r_state)
            S_IDLE:  o_ctrl.ready = 1'b1;
            S_DOT_M: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.mop    = MOP_DOT;
            end
            S_DOT_W: o_ctrl.wb = WB_DOT;
            S_SAT:   o_ctrl.wb = WB_SAT;
            S_X_M: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.mop    = MOP_X;
            end
            S_X_W:   o_ctrl.wb = WB_X;
            S_SER_M: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.mop    = MOP_SER;
            end
            S_SER_W: o_ctrl.wb = WB_SER;
            S_DIV_M: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.mop    = MOP_DIV;
            end
            S_DIV_W: o_ctrl.wb = WB_DIV;
            S_SQ_M: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.mop    = MOP_SQ;
            end
            S_SQ_W:  o_ctrl.wb = WB_SQ;
            S_ERND:  o_ctrl.wb = WB_ERND;
            S_SC_M: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.mop    = MOP_SCL;
            end
            S_SC_W:  o_ctrl.wb = WB_SCL;
            S_DEC:   o_ctrl.wb = i_stat.out_free ? WB_DEC : WB_NONE;
            default: o_ctrl.wb = WB_NONE;
        endcase
    end

endmodule

[hw/rtl/event_triggered_state_feedback_unit.sv]
// Event-triggered state feedback drive: top level, registers and datapath.
//
// Input stream (s side): one beat per sample carries the plant state, the
// reference and the time. The block forms the candidate drive
// K*x + gain_ref*r in Q16.16 (exact sum, floored, saturated) and loads it
// into the held drive when time is zero or when |candidate - held| reaches
// floor_level + decay_scale*exp(-decay_rate*time).
// Output stream (m side): one beat per sample, the held drive in tdata and
// a fired flag in tuser.
// All multiplications run through one 33x33 multiplier with a registered
// product; each multiply is issued in one state and written back in the
// next, and a sample passes through the dot product, the exp series of ten
// terms with reciprocal division, eight squarings, threshold scale and
// decision. At time zero the exp path is skipped; when the exponent reaches
// 16 it is skipped too. The result beat is valid in the cycle after the
// decision step.
// tready on the input is high only out of reset with the sequencer idle. A
// waiting result does not block the next input beat; the decision step holds
// until the output register is free when the receiver stalls.
// Synchronous reset clears config, sequencer, held drive and output valid.
module event_triggered_state_feedback_unit
    import etsf_pkg::*;
#(
    parameter int STATE_DIM = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // state_0, state_1, state_2, state_3, reference, time_now (31b), pad
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // drive_out
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // fired
    output logic                   o_m_tuser,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int NUM_ACT = (STATE_DIM < NUM_STATE_IN) ? STATE_DIM : NUM_STATE_IN;

    // configuration
    logic signed [DATA_W-1:0] r_gain [NUM_ACT];
    logic signed [DATA_W-1:0] r_gain_ref;
    logic [UQ_W-1:0]          r_floor;
    logic [UQ_W-1:0]          r_dscale;
    logic [UQ_W-1:0]          r_drate;

    // sample
    logic signed [DATA_W-1:0] r_st [NUM_ACT];
    logic signed [DATA_W-1:0] r_ref;
    logic [UQ_W-1:0]          r_time;

    // working registers
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DATA_W-1:0] r_cand;
    logic [Y_W-1:0]           r_y;
    logic [Y_W-1:0]           r_raw;
    logic [31:0]              r_term;
    logic signed [32:0]       r_sum;
    logic [31:0]              r_sq;
    logic [E_W-1:0]           r_e;
    logic [31:0]              r_thr;

    // held drive and output register
    logic signed [DATA_W-1:0] r_held;
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_drive;
    logic                     r_out_fired;

    t_ctrl ctrl;
    t_stat stat;

    logic                     w_in_acc;
    logic signed [MUL_W-1:0]  w_a, w_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [SHIFT_W-1:0] w_shift;
    logic [Y_W-1:0]           w_raw;
    logic [31:0]              w_term;
    logic signed [32:0]       w_new_sum;
    logic [63:0]              w_sq_rnd;
    logic [31:0]              w_e_rnd;
    logic signed [32:0]       w_diff;
    logic [32:0]              w_mag;
    logic                     w_fire;

    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign o_s_tready = ctrl.ready && i_rst_n;

    assign stat.time_zero = (r_time == '0);
    assign stat.exp_cut   = |w_prod[PROD_W-1:36];
    assign stat.out_free  = !r_out_valid || i_m_tready;

    etsf_seq #(
        .N_ACT(NUM_ACT)
    ) u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_in_acc),
        .i_stat (stat),
        .o_ctrl (ctrl)
    );

    // operand select for the shared multiplier
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (ctrl.mop)
            MOP_DOT: begin
                w_a = MUL_W'(r_gain_ref);
                w_b = MUL_W'(r_ref);
                for (int i = 0; i < NUM_ACT; i++) begin
                    if (ctrl.k == K_W'(i)) begin
                        w_a = MUL_W'(r_gain[i]);
                        w_b = MUL_W'(r_st[i]);
                    end
                end
            end
            MOP_X: begin
                w_a = MUL_W'({1'b0, r_drate});
                w_b = MUL_W'({1'b0, r_time});
            end
            MOP_SER: begin
                w_a = {1'b0, r_term};
                w_b = MUL_W'({1'b0, r_y});
            end
            MOP_DIV: begin
                w_a = MUL_W'({1'b0, r_raw});
                w_b = {1'b0, f_recip(ctrl.k)};
            end
            MOP_SQ: begin
                w_a = {1'b0, r_sq};
                w_b = {1'b0, r_sq};
            end
            MOP_SCL: begin
                w_a = MUL_W'({1'b0, r_dscale});
                w_b = MUL_W'({1'b0, r_e});
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    etsf_mul u_mul (
        .i_clk (i_clk),
        .i_en  (ctrl.mul_en),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_prod(w_prod)
    );

    // write-back helpers
    assign w_shift   = r_acc[ACC_W-1:16];
    assign w_raw     = w_prod[57:31];
    assign w_term    = (ctrl.wb == WB_SER) ? 32'(w_raw) : w_prod[63:32];
    // odd series powers subtract
    assign w_new_sum = ctrl.k[0] ? (r_sum - $signed({1'b0, w_term}))
                                 : (r_sum + $signed({1'b0, w_term}));
    assign w_sq_rnd  = 64'(w_prod) + SQ_HALF;
    assign w_e_rnd   = r_sq + E_HALF;
    assign w_diff    = 33'(r_cand) - 33'(r_held);
    assign w_mag     = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
    assign w_fire    = stat.time_zero || (w_mag >= {1'b0, r_thr});

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ACT; i++) begin
                r_gain[i] <= '0;
            end
            r_gain_ref <= '0;
            r_floor    <= '0;
            r_dscale   <= '0;
            r_drate    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index) inside
                REG_GAIN_0, REG_GAIN_1, REG_GAIN_2, REG_GAIN_3: begin
                    for (int i = 0; i < NUM_ACT; i++) begin
                        if (i_cfg_index == CFG_IDX_W'(i)) begin
                            r_gain[i] <= i_cfg_data;
                        end
                    end
                end
                REG_GAIN_REF:    r_gain_ref <= i_cfg_data;
                REG_FLOOR_LEVEL: r_floor    <= i_cfg_data[UQ_W-1:0];
                REG_DECAY_SCALE: r_dscale   <= i_cfg_data[UQ_W-1:0];
                REG_DECAY_RATE:  r_drate    <= i_cfg_data[UQ_W-1:0];
                default: ;
            endcase
        end
    end

    // sample capture
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            for (int i = 0; i < NUM_ACT; i++) begin
                r_st[i] <= i_s_tdata[32*i +: 32];
            end
            r_ref  <= i_s_tdata[128 +: 32];
            r_time <= i_s_tdata[160 +: UQ_W];
        end
    end

    // datapath write-back
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_acc <= '0;
        end
        case (ctrl.wb)
            WB_DOT: r_acc <= r_acc + w_prod;
            WB_SAT: begin
                if (w_shift > SAT_HI) begin
                    r_cand <= CAND_MAX;
                end else if (w_shift < SAT_LO) begin
                    r_cand <= CAND_MIN;
                end else begin
                    r_cand <= w_shift[DATA_W-1:0];
                end
            end
            WB_X: begin
                r_y    <= w_prod[35:9];
                r_term <= ONE_Q31;
                r_sum  <= 33'(ONE_Q31);
                r_e    <= '0;
            end
            WB_SER: begin
                if (ctrl.k == K_FIRST_TERM) begin
                    r_term <= w_term;
                    r_sum  <= w_new_sum;
                    r_sq   <= w_new_sum[32] ? 32'd0 : w_new_sum[31:0];
                end else begin
                    r_raw <= w_raw;
                end
            end
            WB_DIV: begin
                r_term <= w_term;
                r_sum  <= w_new_sum;
                r_sq   <= w_new_sum[32] ? 32'd0 : w_new_sum[31:0];
            end
            WB_SQ:   r_sq  <= w_sq_rnd[62:31];
            WB_ERND: r_e   <= w_e_rnd[31:15];
            WB_SCL:  r_thr <= 32'(r_floor) + 32'(w_prod[46:16]);
            default: ;
        endcase
    end

    // held drive and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ctrl.wb == WB_DEC) begin
                r_out_valid <= 1'b1;
                if (w_fire) begin
                    r_held <= r_cand;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.wb == WB_DEC) begin
            r_out_drive <= w_fire ? r_cand : r_held;
            r_out_fired <= w_fire;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_drive;
    assign o_m_tuser  = r_out_fired;

`ifndef SYNTHESIS
    // a pending result always shows the held drive
    a_out_matches_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata == r_held))
        else $error("output drive differs from held drive");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("ready while a sample is in progress");

    a_exp_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.wb == WB_SCL) |-> (r_e <= E_ONE))
        else $error("exp result above 1.0");

    a_time_zero_fires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.wb == WB_DEC && r_time == '0) |=> (o_m_tvalid && o_m_tuser))
        else $error("time zero sample did not fire");
`endif

endmodule

[sim/testbench.sv]
// Self-checking testbench for the event-triggered state feedback unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import etsf_pkg::*;

    localparam int STATE_DIM     = 4;
    localparam int NUM_DIRECTED  = 20;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 88;
    localparam int IDLE_MODES    = 4;
    localparam int IDLE_HEAVY    = 62;
    localparam int IDLE_LIGHT    = 8;
    localparam int MAX_GAP       = 90;
    localparam int TAIL_CYCLES   = 80;
    localparam int TIMEOUT_NS    = 15_000_000;
    localparam int EXP_TERMS     = 10;
    localparam int EXP_SQUARINGS = 8;

    localparam logic [1:0] SET_RESET = 2'd0;
    localparam logic [1:0] SET_MAX   = 2'd1;
    localparam logic [1:0] SET_FLAT  = 2'd2;   // zero decay rate, fixed threshold of 4.5
    localparam logic [1:0] SET_DECAY = 2'd3;

    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_NEG_LSB = 32'hFFFF_FFFF;
    localparam logic [UQ_W-1:0]   T_MAX = 31'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] EXTREMES [5] = '{Q_MAX, Q_MIN, 32'h0, 32'h1, Q_NEG_LSB};

    localparam longint DRIVE_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint DRIVE_MIN = -64'sh0000_0000_8000_0000;
    localparam longint unsigned EXP_CUTOFF = 64'd16 << 32;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // same layout as the input tdata
    typedef struct packed {
        logic                                pad;
        logic [UQ_W-1:0]                     t_now;
        logic [DATA_W-1:0]                   refsig;
        logic [NUM_STATE_IN-1:0][DATA_W-1:0] x;
    } t_sample;

    typedef struct packed {
        logic [DATA_W-1:0]     g0, g1, g2, g3, gain_r;
        logic [CFG_DATA_W-1:0] floor_lvl, scale, rate;
    } t_gains;

    typedef struct packed {
        logic [DATA_W-1:0] drive;
        logic              fired;
    } t_drive;

    typedef struct packed {
        logic [1:0]        set;
        logic [DATA_W-1:0] x0, x1, x2, x3, r;
        logic [UQ_W-1:0]   t;
        logic              pad;
        logic              known;
        logic [DATA_W-1:0] drive;
        logic              fired;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;    // drive_out
    logic                   o_m_tuser;    // fired
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // mirror of the block's registers and held drive
    logic signed [DATA_W-1:0] gain_q [NUM_STATE_IN] = '{default: '0};
    logic signed [DATA_W-1:0] gain_ref_q = '0;
    longint unsigned          floor_q = 0;
    longint unsigned          scale_q = 0;
    longint unsigned          rate_q = 0;
    longint                   held_q = 0;

    t_drive     expected_drive_q [$];
    t_idle_mode idle_mode = IDLE_NONE;
    int         errors = 0;
    t_gains     reg_sets [4];
    t_row       dir_rows [NUM_DIRECTED];

    always #6 i_clk = ~i_clk;

    event_triggered_state_feedback_unit #(
        .STATE_DIM (STATE_DIM)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // exp(-x) in Q16.16, x in Q32.32: scaled series, then repeated squaring
    function automatic longint unsigned decay_factor(longint unsigned xq);
        longint y, term, sum;
        if (xq >= EXP_CUTOFF) return 0;
        y = longint'(xq >> 9);
        term = 64'sd1 <<< 31;
        sum = term;
        for (int k = 1; k <= EXP_TERMS; k++) begin
            term = ((term * y) >>> 31) / k;
            sum = (k % 2 == 1) ? sum - term : sum + term;
        end
        if (sum < 0) sum = 0;
        repeat (EXP_SQUARINGS) sum = (sum * sum + (64'sd1 <<< 30)) >>> 31;
        return $unsigned((sum + (64'sd1 <<< 14)) >>> 15);
    endfunction

    function automatic t_drive predict_drive(t_sample s);
        logic signed [69:0] acc;
        logic signed [69:0] cand_wide;
        longint             cand, diff;
        longint unsigned    thr, mag;
        bit                 fire;
        acc = '0;
        for (int i = 0; i < NUM_STATE_IN && i < STATE_DIM; i++)
            acc += longint'(gain_q[i]) * longint'($signed(s.x[i]));
        acc += longint'(gain_ref_q) * longint'($signed(s.refsig));
        cand_wide = acc >>> 16;
        if (cand_wide > DRIVE_MAX)
            cand = DRIVE_MAX;
        else if (cand_wide < DRIVE_MIN)
            cand = DRIVE_MIN;
        else
            cand = longint'(cand_wide);
        if (s.t_now == '0) begin
            fire = 1'b1;
        end else begin
            thr = floor_q + ((scale_q * decay_factor(rate_q * s.t_now)) >> 16);
            diff = cand - held_q;
            mag = (diff < 0) ? $unsigned(-diff) : $unsigned(diff);
            fire = (mag >= thr);
        end
        if (fire) held_q = cand;
        return '{drive: held_q[31:0], fired: fire};
    endfunction

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 512) - 256;
            2: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
            3, 4: return $urandom_range(0, 32'h80_0000) - 32'h40_0000;
            default: return EXTREMES[$urandom_range(0, 4)];
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_GAIN_0:      gain_q[0] = val;
            REG_GAIN_1:      gain_q[1] = val;
            REG_GAIN_2:      gain_q[2] = val;
            REG_GAIN_3:      gain_q[3] = val;
            REG_GAIN_REF:    gain_ref_q = val;
            REG_FLOOR_LEVEL: floor_q = 64'(val[UQ_W-1:0]);
            REG_DECAY_SCALE: scale_q = 64'(val[UQ_W-1:0]);
            REG_DECAY_RATE:  rate_q = 64'(val[UQ_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic load_regs(input t_gains g);
        write_reg(REG_GAIN_0, g.g0);
        write_reg(REG_GAIN_1, g.g1);
        write_reg(REG_GAIN_2, g.g2);
        write_reg(REG_GAIN_3, g.g3);
        write_reg(REG_GAIN_REF, g.gain_r);
        write_reg(REG_FLOOR_LEVEL, g.floor_lvl);
        write_reg(REG_DECAY_SCALE, g.scale);
        write_reg(REG_DECAY_RATE, g.rate);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // drop valid and wait for every outstanding result
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (expected_drive_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic send_sample(input t_sample s, input bit known, input t_drive want);
        t_drive predicted;
        int     gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? IDLE_HEAVY :
                  (idle_mode == IDLE_BOTH)   ? IDLE_LIGHT : 0;
        if ($urandom_range(0, 99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= s;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = predict_drive(s);
        expected_drive_q.push_back(known ? want : predicted);
    endtask

    // result side: check each beat, then pick next cycle's tready
    always @(posedge i_clk) begin : result_check
        t_drive want;
        int     stall_pct;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_drive_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat drive_out %h fired %b",
                         $time, o_m_tdata, o_m_tuser);
            end else begin
                want = expected_drive_q.pop_front();
                if (o_m_tdata !== want.drive) begin
                    errors++;
                    $display("%0t: drive_out expected %h got %h", $time, want.drive, o_m_tdata);
                end
                if (o_m_tuser !== want.fired) begin
                    errors++;
                    $display("%0t: fired expected %b got %b", $time, want.fired, o_m_tuser);
                end
            end
        end
        stall_pct = (idle_mode == IDLE_RECEIVER) ? IDLE_HEAVY :
                    (idle_mode == IDLE_BOTH)     ? IDLE_LIGHT : 0;
        i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial begin
        #(TIMEOUT_NS);
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        t_sample s;
        t_gains  g;
        int      cur_set;
        reg_sets = '{
            '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
            '{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 32'hFFFF_FFFF, Q_MAX},
            '{Q_ONE, 32'hFFFF_8000, 32'h0002_0000, 32'h0000_4000, Q_ONE,
              32'h0000_8000, 32'h0004_0000, 32'h0},
            '{Q_MIN, 32'h1, 32'h0, Q_NEG_LSB, Q_ONE, 32'h0, Q_ONE, Q_ONE}
        };
        // set, state_0..3, reference, time, pad, typed-in, drive, fired
        dir_rows = '{
            '{SET_RESET, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 1'b1, 32'h0, 1'b1},
            '{SET_RESET, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, T_MAX, 1'b0, 1'b1, 32'h0, 1'b1},
            '{SET_RESET, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 31'h1, 1'b1, 1'b1, 32'h0, 1'b1},
            // saturation both ways, then the widest difference against the highest floor
            '{SET_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 31'h0, 1'b0, 1'b1, Q_MAX, 1'b1},
            '{SET_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 31'h0, 1'b1, 1'b1, Q_MIN, 1'b1},
            '{SET_MAX, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, T_MAX, 1'b0, 1'b1, 32'h0, 1'b1},
            '{SET_MAX, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, T_MAX, 1'b0, 1'b1, 32'h0, 1'b0},
            '{SET_MAX, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0, T_MAX, 1'b0, 1'b1, 32'h0, 1'b0},
            '{SET_FLAT, Q_ONE, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 1'b1, Q_ONE, 1'b1},
            '{SET_FLAT, 32'h5_0000, 32'h0, 32'h0, 32'h0, 32'h0, 31'h5, 1'b0, 1'b0, 32'h0, 1'b0},
            '{SET_FLAT, 32'h5_8000, 32'h0, 32'h0, 32'h0, 32'h0, 31'h1_0000, 1'b0, 1'b0,
              32'h0, 1'b0},
            '{SET_FLAT, 32'h0, 32'h2_0000, 32'hFFFF_0000, 32'h1, 32'h3_0000, T_MAX, 1'b0,
              1'b0, 32'h0, 1'b0},
            '{SET_FLAT, 32'h0, 32'h0, 32'h0, Q_NEG_LSB, 32'h0, 31'h1, 1'b0, 1'b0, 32'h0, 1'b0},
            '{SET_DECAY, 32'h0, 32'h0, 32'h0, 32'h0, 32'h2_0000, 31'h0, 1'b0, 1'b1,
              32'h2_0000, 1'b1},
            '{SET_DECAY, 32'h0, 32'h0, 32'h0, 32'h0, 32'h2_8000, 31'h1, 1'b0, 1'b0, 32'h0, 1'b0},
            '{SET_DECAY, 32'h0, 32'h0, 32'h0, 32'h0, 32'h3_8000, 31'h1_0000, 1'b0, 1'b0,
              32'h0, 1'b0},
            // just below and exactly at the exp cutoff
            '{SET_DECAY, 32'h0, 32'h0, 32'h0, 32'h0, 32'h3_9000, 31'hF_FFFF, 1'b0, 1'b0,
              32'h0, 1'b0},
            '{SET_DECAY, 32'h0, 32'h0, 32'h0, 32'h0, 32'h3_9000, 31'h10_0000, 1'b0, 1'b0,
              32'h0, 1'b0},
            '{SET_DECAY, Q_ONE, Q_MAX, 32'h0, Q_MIN, Q_ONE, 31'h8000, 1'b1, 1'b0, 32'h0, 1'b0},
            '{SET_DECAY, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 31'h4_0000, 1'b0, 1'b0, 32'h0, 1'b0}
        };
        cur_set = -1;
        s = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < NUM_DIRECTED; n++) begin
            if (int'(dir_rows[n].set) != cur_set) begin
                drain();
                cur_set = int'(dir_rows[n].set);
                load_regs(reg_sets[cur_set]);
            end
            s.x[0] = dir_rows[n].x0;
            s.x[1] = dir_rows[n].x1;
            s.x[2] = dir_rows[n].x2;
            s.x[3] = dir_rows[n].x3;
            s.refsig = dir_rows[n].r;
            s.t_now = dir_rows[n].t;
            s.pad = dir_rows[n].pad;
            send_sample(s, dir_rows[n].known, '{drive: dir_rows[n].drive,
                                                fired: dir_rows[n].fired});
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            idle_mode = t_idle_mode'(ph % IDLE_MODES);
            g.g0 = random_word();
            g.g1 = random_word();
            g.g2 = random_word();
            g.g3 = random_word();
            g.gain_r = random_word();
            g.floor_lvl = random_word();
            g.scale = random_word();
            g.rate = random_word();
            load_regs(g);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sometimes nudge the last sample so the candidate lands near the held drive
                if (n > 0 && $urandom_range(0, 3) == 0) begin
                    s.refsig = s.refsig + ($urandom_range(0, 512) - 256);
                end else begin
                    for (int i = 0; i < NUM_STATE_IN; i++) s.x[i] = random_word();
                    s.refsig = random_word();
                end
                case ($urandom_range(0, 15))
                    0:                         s.t_now = '0;
                    1, 2, 3, 4, 5, 6, 7, 8, 9: s.t_now = UQ_W'($urandom_range(1, 32'h8_0000));
                    default:                   s.t_now = UQ_W'($urandom);
                endcase
                s.pad = 1'($urandom_range(0, 1));
                send_sample(s, 1'b0, '0);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
